### src/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } text_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_closed;
    logic       run_last;
  } utf8_t;

  typedef enum logic [2:0] {
    PM_TEXT       = 3'd0,
    PM_ESC        = 3'd1,
    PM_HEX        = 3'd2,
    PM_AFTER_HIGH = 3'd3,
    PM_SKIP       = 3'd4,
    PM_LOW        = 3'd5
  } parse_mode_t;

  // one parsed item: an optional code point to encode, then an optional single result
  typedef struct packed {
    logic        cp_en;
    logic [20:0] cp;
    logic        tail_en;
    logic [7:0]  tail_byte;
    logic        tail_valid;
    logic        tail_closed;
  } cmd_t;

  localparam int DEF_QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

### src/jsu_front.sv
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire text_t text,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_BSLASH  = 8'h5C;
  localparam logic [15:0] HIGH_BASE  = 16'hD800;
  localparam logic [15:0] LOW_BASE   = 16'hDC00;
  localparam logic [20:0] PLANE1     = 21'h10000;

  parse_mode_t parse_mode, parse_mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [2:0]  hex_count, hex_count_next;
  logic        hex_stopped, hex_stopped_next;
  logic [15:0] high_half, high_half_next;
  logic        finished, finished_next;

  logic [7:0]  c;
  logic        eoi;
  logic        active;
  logic        is_hex;
  logic [3:0]  digit;
  logic [15:0] acc_abs;
  logic        stop_abs;
  logic [2:0]  cnt_abs;
  logic        grp_done;
  logic        acc_is_high;
  logic [20:0] pair_cp;

  function automatic logic [7:0] esc_map(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      8'h6E:   r = 8'h0A;   // n
      8'h74:   r = 8'h09;   // t
      8'h72:   r = 8'h0D;   // r
      8'h62:   r = 8'h08;   // b
      8'h66:   r = 8'h0C;   // f
      8'h75:   r = 8'h00;   // u with no digits left
      default: r = ch;
    endcase
    return r;
  endfunction

  assign c      = text.in_byte;
  assign eoi    = text.end_of_input;
  assign active = accept && !finished;

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      digit = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // leading hex run only; later digits after a stop are dropped
  assign acc_abs     = (!hex_stopped && is_hex) ? {hex_accum[11:0], digit} : hex_accum;
  assign stop_abs    = hex_stopped | ~is_hex;
  assign cnt_abs     = hex_count + 3'd1;
  assign grp_done    = (cnt_abs >= 3'd4) || eoi;
  assign acc_is_high = (acc_abs >= HIGH_BASE) && (acc_abs < LOW_BASE);
  // stays in 0x2400..0x111fff since high_half is always a high surrogate
  assign pair_cp     = PLANE1 + {1'b0, high_half[9:0], 10'b0} + {5'b0, acc_abs}
                       - {5'b0, LOW_BASE};

  // next state
  always_comb begin
    parse_mode_next  = parse_mode;
    hex_accum_next   = hex_accum;
    hex_count_next   = hex_count;
    hex_stopped_next = hex_stopped;
    high_half_next   = high_half;
    finished_next    = finished;
    if (active) begin
      case (parse_mode)
        PM_ESC: begin
          parse_mode_next = PM_TEXT;
          if (c == 8'h75 && !eoi) begin
            parse_mode_next  = PM_HEX;
            hex_accum_next   = 16'd0;
            hex_count_next   = 3'd0;
            hex_stopped_next = 1'b0;
          end
        end
        PM_HEX: begin
          hex_accum_next   = acc_abs;
          hex_count_next   = cnt_abs;
          hex_stopped_next = stop_abs;
          if (grp_done) begin
            parse_mode_next = PM_TEXT;
            if (acc_is_high && !eoi) begin
              high_half_next  = acc_abs;
              parse_mode_next = PM_AFTER_HIGH;
            end
          end
        end
        PM_AFTER_HIGH: begin
          parse_mode_next = PM_TEXT;
          if (c == CH_BSLASH && !eoi) begin
            parse_mode_next = PM_SKIP;
          end else if (c == CH_QUOTE) begin
            finished_next = 1'b1;
          end
        end
        PM_SKIP: begin
          if (eoi) begin
            parse_mode_next = PM_TEXT;
          end else begin
            parse_mode_next  = PM_LOW;
            hex_accum_next   = 16'd0;
            hex_count_next   = 3'd0;
            hex_stopped_next = 1'b0;
          end
        end
        PM_LOW: begin
          hex_accum_next   = acc_abs;
          hex_count_next   = cnt_abs;
          hex_stopped_next = stop_abs;
          if (grp_done) begin
            parse_mode_next = PM_TEXT;
          end
        end
        default: begin
          parse_mode_next = PM_TEXT;
          if (c == CH_QUOTE) begin
            finished_next = 1'b1;
          end else if (c == CH_BSLASH && !eoi) begin
            parse_mode_next = PM_ESC;
          end
        end
      endcase
    end
  end

  // command for the back end
  always_comb begin
    cmd             = '0;
    cmd.tail_valid  = 1'b1;
    case (parse_mode)
      PM_ESC: begin
        if (!(c == 8'h75 && !eoi)) begin
          cmd.tail_en   = 1'b1;
          cmd.tail_byte = esc_map(c);
        end
      end
      PM_HEX: begin
        if (grp_done && !(acc_is_high && !eoi)) begin
          cmd.cp_en = 1'b1;
          cmd.cp    = {5'b0, acc_abs};
        end
      end
      PM_AFTER_HIGH: begin
        if (!(c == CH_BSLASH && !eoi)) begin
          cmd.cp_en   = 1'b1;
          cmd.cp      = {5'b0, high_half};
          cmd.tail_en = 1'b1;
          if (c == CH_QUOTE) begin
            cmd.tail_valid  = 1'b0;
            cmd.tail_closed = 1'b1;
          end else begin
            cmd.tail_byte = c;
          end
        end
      end
      PM_SKIP: begin
        if (eoi) begin
          cmd.cp_en     = 1'b1;
          cmd.cp        = {5'b0, high_half};
          cmd.tail_en   = 1'b1;
          cmd.tail_byte = esc_map(c);
        end
      end
      PM_LOW: begin
        if (grp_done) begin
          cmd.cp_en = 1'b1;
          cmd.cp    = pair_cp;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          cmd.tail_en     = 1'b1;
          cmd.tail_valid  = 1'b0;
          cmd.tail_closed = 1'b1;
        end else if (!(c == CH_BSLASH && !eoi)) begin
          cmd.tail_en   = 1'b1;
          cmd.tail_byte = c;
        end
      end
    endcase
    push = active && (cmd.cp_en || cmd.tail_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode  <= PM_TEXT;
      hex_accum   <= 16'd0;
      hex_count   <= 3'd0;
      hex_stopped <= 1'b0;
      high_half   <= 16'd0;
      finished    <= 1'b0;
    end else begin
      parse_mode  <= parse_mode_next;
      hex_accum   <= hex_accum_next;
      hex_count   <= hex_count_next;
      hex_stopped <= hex_stopped_next;
      high_half   <= high_half_next;
      finished    <= finished_next;
    end
  end

endmodule

`default_nettype wire

### src/jsu_fifo.sv
`default_nettype none

module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int WIDTH = $bits(cmd_t)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign rdata = mem[rd_ptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/jsu_back.sv
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire cmd_t  q_head,
  output logic       q_pop,
  output logic       utf8_valid,
  output utf8_t      utf8,
  input  wire logic  utf8_stall
);

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;

  logic        cur_valid;
  utf8_t [3:0] ents;
  utf8_t [3:0] ents_next;
  logic [1:0]  last_idx, last_idx_next;
  logic [1:0]  idx;

  logic [20:0] cp_c;
  logic [1:0]  lenm1;
  logic [7:0]  enc [4];
  logic        done;
  logic        load;

  // utf-8 encoding of the queue head
  always_comb begin
    cp_c = (q_head.cp > CP_MAX) ? CP_REPLACE : q_head.cp;
    enc[0] = cp_c[7:0];
    enc[1] = 8'h00;
    enc[2] = 8'h00;
    enc[3] = 8'h00;
    lenm1  = 2'd0;
    if (cp_c < 21'h80) begin
      lenm1 = 2'd0;
    end else if (cp_c < 21'h800) begin
      lenm1  = 2'd1;
      enc[0] = {3'b110, cp_c[10:6]};
      enc[1] = {2'b10, cp_c[5:0]};
    end else if (cp_c < 21'h10000) begin
      lenm1  = 2'd2;
      enc[0] = {4'b1110, cp_c[15:12]};
      enc[1] = {2'b10, cp_c[11:6]};
      enc[2] = {2'b10, cp_c[5:0]};
    end else begin
      lenm1  = 2'd3;
      enc[0] = {5'b11110, cp_c[20:18]};
      enc[1] = {2'b10, cp_c[17:12]};
      enc[2] = {2'b10, cp_c[11:6]};
      enc[3] = {2'b10, cp_c[5:0]};
    end
  end

  always_comb begin
    last_idx_next = q_head.cp_en ? lenm1 + {1'b0, q_head.tail_en} : 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (q_head.cp_en && 2'(i) <= lenm1) begin
        ents_next[i].out_byte      = enc[i];
        ents_next[i].byte_valid    = 1'b1;
        ents_next[i].string_closed = 1'b0;
      end else begin
        ents_next[i].out_byte      = q_head.tail_byte;
        ents_next[i].byte_valid    = q_head.tail_valid;
        ents_next[i].string_closed = q_head.tail_closed;
      end
      ents_next[i].run_last = (2'(i) == last_idx_next);
    end
  end

  assign done       = cur_valid && !utf8_stall && (idx == last_idx);
  assign load       = !q_empty && (!cur_valid || done);
  assign q_pop      = load;
  assign utf8_valid = cur_valid;
  assign utf8       = ents[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (cur_valid && !utf8_stall) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents     <= ents_next;
      last_idx <= last_idx_next;
    end
  end

endmodule

`default_nettype wire

### src/json_string_unescaper_top.sv
// channel | role   | handshake               | payload
// text    | input  | text_valid / text_stall | text_t: in_byte, end_of_input
// utf8    | output | utf8_valid / utf8_stall | utf8_t: out_byte, byte_valid,
//         |        |                         |   string_closed, run_last
//
// one text byte is taken per cycle while the command queue has room; the parser
// resolves it in that cycle and queues at most one command
// the encoder sends one result per cycle unless utf8_stall holds it, so an item gives 1 to 4 results,
// set by the length of its utf-8 code plus any trailing byte or marker
// the queue holds QUEUE_DEPTH commands; text stalls only while it is full
// synchronous reset clears parser state, queue and output
`default_nettype none

module json_string_unescaper_top import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  text_valid,
  output logic       text_stall,
  input  wire text_t text,
  output logic       utf8_valid,
  input  wire logic  utf8_stall,
  output utf8_t      utf8
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic pop;
  logic q_full;
  logic q_empty;

  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .text   (text),
    .push   (push),
    .cmd    (push_cmd)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(cmd_t))
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (head_cmd),
    .q_pop      (pop),
    .utf8_valid (utf8_valid),
    .utf8       (utf8),
    .utf8_stall (utf8_stall)
  );

  // the queue is never written while full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("push into full queue");

  // results of one item go out back to back
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (utf8_valid && !utf8_stall && !utf8.run_last) |=> utf8_valid)
    else $error("gap inside an item's results");

  // a marker-only beat is always the close marker and the item's last result
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (utf8_valid && !utf8.byte_valid) |-> (utf8.string_closed && utf8.run_last))
    else $error("bad marker beat");

  // nothing follows the close marker
  a_quiet_after_close: assert property (@(posedge clk) disable iff (rst)
    (utf8_valid && !utf8_stall && utf8.string_closed) |=> !utf8_valid)
    else $error("result after close marker");

endmodule

`default_nettype wire
